>>> design/mx86_pkg.sv
`timescale 1ns / 1ps
package mx86_pkg;
    localparam int MEM_ADDR_BITS_DEF = 16;
    localparam int MAX_PREFIXES = 14;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2,
        OP_STEP    = 2'd3
    } op_t;

    localparam logic [7:0] OPC_ADD  = 8'h01;
    localparam logic [7:0] OPC_XOR  = 8'h31;
    localparam logic [7:0] OPC_MOV  = 8'h89;
    localparam logic [7:0] OPC_MOVA = 8'hB8;
    localparam logic [7:0] OPC_MOVC = 8'hB9;
    localparam logic [7:0] OPC_GRP5 = 8'hFF;
    localparam logic [7:0] OPC_CMP  = 8'h83;
    localparam logic [7:0] OPC_JNE  = 8'h75;
    localparam logic [7:0] OPC_JMP  = 8'hEB;
    localparam logic [7:0] OPC_HLT  = 8'hF4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEMRD,
        ST_PREFIX,
        ST_MODRM,
        ST_DISP8,
        ST_IMM4,
        ST_DATA4,
        ST_STORE,
        ST_JUMP,
        ST_IMM1,
        ST_DONE
    } state_t;

    // purpose of the 4-byte gather
    typedef enum logic [1:0] {
        G_DISP32,
        G_MOVIMM,
        G_CMPIMM
    } gather_t;
endpackage

>>> design/mini_x86_decode_execute_unit.sv
`timescale 1ns / 1ps
// Load and restart go straight to the done state; a read passes through a memory-read state.
// A step fetches each prefix byte and each modrm, displacement and immediate byte in turn;
// add/xor to memory first read four data bytes, and every store writes eight bytes.
// The longest step is add/xor to memory with disp32 after 14 prefixes.
// One transaction in flight; the next is accepted only after the result has been taken.
// Reset (aresetn low, synchronous): registers, pc and zero flag cleared; memory untouched.
module mini_x86_decode_execute_unit #(
    parameter int MEM_ADDR_BITS = mx86_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], address[33:2], data[97:34], zero pad
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[31:0], zero_flag[32], opcode[40:33], reg_write_valid[41],
    // reg_index[44:42], reg_value[108:45], mem_write_valid[109],
    // mem_address[141:110], mem_data[205:142], read_byte[213:206], zero pad
    output logic [215:0] m_tdata
);
    localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;

    logic [7:0] mem [MEM_DEPTH];
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [7:0] mem_wdata, mem_rdata;
    logic       mem_we;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        mem_rdata <= mem[mem_addr];
    end

    logic [63:0] regs_reg [8];
    logic [63:0] regs_next [8];
    mx86_pkg::state_t state_reg, state_next;
    logic [31:0] pc_reg, pc_next;
    logic        zf_reg, zf_next;
    logic [63:0] data_reg, data_next;
    logic [3:0]  npfx_reg, npfx_next;
    logic [7:0]  opc_reg, opc_next;
    logic [7:0]  modrm_reg, modrm_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] ea_reg, ea_next;
    mx86_pkg::gather_t g_reg, g_next;
    logic        rw_reg, rw_next, mw_reg, mw_next;
    logic [2:0]  ridx_reg, ridx_next;
    logic [63:0] rval_reg, rval_next;
    logic [63:0] mdat_reg, mdat_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        ovalid_reg, ovalid_next;

    logic [2:0]  m_reg3, m_rm;
    logic [31:0] fetch_pc;
    logic [31:0] ea_off;
    logic [63:0] rm_val, reg_val;

    assign m_reg3 = modrm_reg[5:3];
    assign m_rm   = modrm_reg[2:0];
    assign rm_val = regs_reg[m_rm];
    assign reg_val = regs_reg[m_reg3];
    assign ea_off = ea_reg + {29'd0, cnt_reg};

    assign s_tready = (state_reg == mx86_pkg::ST_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'b0, rbyte_reg, mdat_reg, ea_reg, mw_reg, rval_reg, ridx_reg,
                       rw_reg, opc_reg, zf_reg, pc_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mx86_pkg::ST_IDLE;
            pc_reg     <= '0;
            zf_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++) regs_reg[i] <= '0;
        end else begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            zf_reg     <= zf_next;
            ovalid_reg <= ovalid_next;
            for (int i = 0; i < 8; i++) regs_reg[i] <= regs_next[i];
        end
        data_reg  <= data_next;
        npfx_reg  <= npfx_next;
        opc_reg   <= opc_next;
        modrm_reg <= modrm_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        ea_reg    <= ea_next;
        g_reg     <= g_next;
        rw_reg    <= rw_next;
        mw_reg    <= mw_next;
        ridx_reg  <= ridx_next;
        rval_reg  <= rval_next;
        mdat_reg  <= mdat_next;
        rbyte_reg <= rbyte_next;
    end

    always_comb begin
        logic [7:0]  b;
        logic        is_pfx;
        logic [31:0] gathered;
        logic [63:0] v;
        state_next = state_reg;
        pc_next = pc_reg; zf_next = zf_reg; ovalid_next = ovalid_reg;
        for (int i = 0; i < 8; i++) regs_next[i] = regs_reg[i];
        data_next = data_reg;
        npfx_next = npfx_reg; opc_next = opc_reg; modrm_next = modrm_reg;
        cnt_next = cnt_reg; acc_next = acc_reg; ea_next = ea_reg; g_next = g_reg;
        rw_next = rw_reg; mw_next = mw_reg; ridx_next = ridx_reg;
        rval_next = rval_reg; mdat_next = mdat_reg; rbyte_next = rbyte_reg;
        mem_we = 1'b0;
        mem_addr = pc_reg[MEM_ADDR_BITS-1:0];
        mem_wdata = data_reg[7:0];
        b = mem_rdata;
        is_pfx = (b[7:4] == 4'h4) || (b == 8'h66) || (b == 8'h67);
        gathered = {b, acc_reg[31:8]};
        fetch_pc = pc_reg + 32'd1;
        v = '0;

        if (ovalid_reg && m_tready) ovalid_next = 1'b0;

        unique case (state_reg)
            mx86_pkg::ST_IDLE: begin
                mem_addr = s_tdata[MEM_ADDR_BITS+1:2];
                if (s_tvalid && s_tready) begin
                    data_next = s_tdata[97:34];
                    opc_next = '0; rw_next = 1'b0; ridx_next = '0; rval_next = '0;
                    mw_next = 1'b0; ea_next = '0; mdat_next = '0; rbyte_next = '0;
                    npfx_next = '0;
                    unique case (mx86_pkg::op_t'(s_tdata[1:0]))
                        mx86_pkg::OP_LOAD: begin
                            mem_we = 1'b1;
                            mem_wdata = s_tdata[41:34];
                            state_next = mx86_pkg::ST_DONE;
                        end
                        mx86_pkg::OP_READ: state_next = mx86_pkg::ST_MEMRD;
                        mx86_pkg::OP_RESTART: begin
                            for (int i = 0; i < 8; i++) regs_next[i] = '0;
                            regs_next[4] = s_tdata[97:34];
                            pc_next = s_tdata[33:2];
                            zf_next = 1'b0;
                            state_next = mx86_pkg::ST_DONE;
                        end
                        default: begin
                            mem_addr = pc_reg[MEM_ADDR_BITS-1:0];
                            pc_next = pc_reg + 32'd1;
                            state_next = mx86_pkg::ST_PREFIX;
                        end
                    endcase
                end
            end
            mx86_pkg::ST_MEMRD: begin
                rbyte_next = mem_rdata;
                state_next = mx86_pkg::ST_DONE;
            end
            mx86_pkg::ST_PREFIX: begin
                // b is the byte at pc_reg-1; pc_reg already points past it
                mem_addr = pc_reg[MEM_ADDR_BITS-1:0];
                if (is_pfx && npfx_reg != 4'(mx86_pkg::MAX_PREFIXES)) begin
                    npfx_next = npfx_reg + 4'd1;
                    pc_next = fetch_pc;
                end else begin
                    opc_next = b;
                    priority case (b)
                        mx86_pkg::OPC_ADD, mx86_pkg::OPC_XOR, mx86_pkg::OPC_MOV,
                        mx86_pkg::OPC_GRP5, mx86_pkg::OPC_CMP: begin
                            pc_next = fetch_pc;
                            state_next = mx86_pkg::ST_MODRM;
                        end
                        mx86_pkg::OPC_MOVA, mx86_pkg::OPC_MOVC: begin
                            pc_next = fetch_pc;
                            cnt_next = '0; g_next = mx86_pkg::G_MOVIMM;
                            state_next = mx86_pkg::ST_IMM4;
                        end
                        mx86_pkg::OPC_JNE, mx86_pkg::OPC_JMP: state_next = mx86_pkg::ST_JUMP;
                        mx86_pkg::OPC_HLT: begin
                            pc_next = '0;
                            state_next = mx86_pkg::ST_DONE;
                        end
                        default: state_next = mx86_pkg::ST_DONE;
                    endcase
                end
            end
            mx86_pkg::ST_MODRM: begin
                modrm_next = b;
                mem_addr = pc_reg[MEM_ADDR_BITS-1:0];
                state_next = mx86_pkg::ST_DONE;
                priority case (opc_reg)
                    mx86_pkg::OPC_GRP5: begin
                        if (b[5:3] == 3'd1) begin
                            v = regs_reg[b[2:0]] - 64'd1;
                            regs_next[b[2:0]] = v;
                            rw_next = 1'b1; ridx_next = b[2:0]; rval_next = v;
                        end
                    end
                    mx86_pkg::OPC_CMP: begin
                        if (b[5:3] == 3'd7 && b[7:6] == 2'd3) begin
                            pc_next = fetch_pc;
                            state_next = mx86_pkg::ST_IMM1;
                        end else if (b[5:3] == 3'd7 && b[7:6] == 2'd0) begin
                            pc_next = fetch_pc;
                            cnt_next = '0; g_next = mx86_pkg::G_CMPIMM;
                            state_next = mx86_pkg::ST_IMM4;
                        end
                    end
                    default: begin
                        if (b[7:6] == 2'd3) begin
                            unique case (opc_reg)
                                mx86_pkg::OPC_ADD: v = regs_reg[b[2:0]] + regs_reg[b[5:3]];
                                mx86_pkg::OPC_XOR: v = regs_reg[b[2:0]] ^ regs_reg[b[5:3]];
                                default:           v = regs_reg[b[5:3]];
                            endcase
                            regs_next[b[2:0]] = v;
                            rw_next = 1'b1; ridx_next = b[2:0]; rval_next = v;
                        end else begin
                            ea_next = regs_reg[b[2:0]][31:0];
                            if (b[7:6] == 2'd1) begin
                                pc_next = fetch_pc;
                                state_next = mx86_pkg::ST_DISP8;
                            end else if (b[7:6] == 2'd2) begin
                                pc_next = fetch_pc;
                                cnt_next = '0; g_next = mx86_pkg::G_DISP32;
                                state_next = mx86_pkg::ST_IMM4;
                            end else begin
                                cnt_next = '0;
                                state_next = mx86_pkg::ST_DATA4;
                            end
                        end
                    end
                endcase
            end
            mx86_pkg::ST_IMM1: begin
                zf_next = (rm_val == {56'd0, b});
                state_next = mx86_pkg::ST_DONE;
            end
            mx86_pkg::ST_DISP8: begin
                ea_next = ea_reg + {{24{b[7]}}, b};
                cnt_next = '0;
                state_next = mx86_pkg::ST_DATA4;
            end
            mx86_pkg::ST_IMM4: begin
                // byte for cnt_reg arrives now; pc_reg points one past it
                acc_next = gathered;
                mem_addr = pc_reg[MEM_ADDR_BITS-1:0];
                if (cnt_reg == 3'd3) begin
                    state_next = mx86_pkg::ST_DONE;
                    unique case (g_reg)
                        mx86_pkg::G_DISP32: begin
                            ea_next = ea_reg + gathered;
                            cnt_next = '0;
                            state_next = mx86_pkg::ST_DATA4;
                        end
                        mx86_pkg::G_MOVIMM: begin
                            v = {32'd0, gathered};
                            regs_next[{2'd0, opc_reg[0]}] = v;
                            rw_next = 1'b1; ridx_next = {2'd0, opc_reg[0]}; rval_next = v;
                        end
                        default: zf_next = (rm_val == {32'd0, gathered});
                    endcase
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                    pc_next = fetch_pc;
                end
            end
            mx86_pkg::ST_DATA4: begin
                // cnt 0: issue addr ea; cnt 1..4 receive bytes 0..3
                mem_addr = ea_off[MEM_ADDR_BITS-1:0];
                if (cnt_reg != 3'd0) acc_next = gathered;
                if (opc_reg == mx86_pkg::OPC_MOV) begin
                    mdat_next = reg_val;
                    cnt_next = '0;
                    state_next = mx86_pkg::ST_STORE;
                end else if (cnt_reg == 3'd4) begin
                    if (opc_reg == mx86_pkg::OPC_ADD) mdat_next = {32'd0, gathered} + reg_val;
                    else mdat_next = {32'd0, gathered} ^ reg_val;
                    cnt_next = '0;
                    state_next = mx86_pkg::ST_STORE;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            mx86_pkg::ST_STORE: begin
                mem_addr = ea_off[MEM_ADDR_BITS-1:0];
                mem_we = 1'b1;
                mem_wdata = mdat_reg[8*cnt_reg +: 8];
                mw_next = 1'b1;
                if (cnt_reg == 3'd7) state_next = mx86_pkg::ST_DONE;
                cnt_next = cnt_reg + 3'd1;
            end
            mx86_pkg::ST_JUMP: begin
                if (opc_reg == mx86_pkg::OPC_JMP || !zf_reg)
                    pc_next = pc_reg + {{24{b[7]}}, b} + 32'd1;
                else
                    pc_next = fetch_pc;
                state_next = mx86_pkg::ST_DONE;
            end
            default: begin
                if (!ovalid_reg) begin
                    ovalid_next = 1'b1;
                    state_next = mx86_pkg::ST_IDLE;
                end
            end
        endcase
    end
endmodule

>>> verif/tb_mini_x86_decode_execute_unit.sv
`timescale 1ns / 1ps
module tb_mini_x86_decode_execute_unit;

    localparam int MA         = mx86_pkg::MEM_ADDR_BITS_DEF;
    localparam int MEM_BYTES  = 1 << MA;
    localparam int N_ITEMS    = 850;
    localparam int CYCLE_CAP  = 600000;

    typedef struct {
        logic [31:0] next_pc;
        logic        zf;
        logic [7:0]  opc;
        logic        rwv;
        logic [2:0]  ridx;
        logic [63:0] rval;
        logic        mwv;
        logic [31:0] maddr;
        logic [63:0] mdata;
        logic [7:0]  rbyte;
    } outcome_t;

    typedef struct {
        mx86_pkg::op_t op;
        logic [31:0] addr;
        logic [63:0] data;
        bit          drain;   // hold back until every result is home
        outcome_t    want;
    } job_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [215:0] m_tdata;

    mini_x86_decode_execute_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    // shadow machine state
    logic [7:0]    shadow_mem [MEM_BYTES];
    bit            loaded     [MEM_BYTES];
    logic [MA-1:0] loaded_list [$];
    logic [63:0]   gpr [8];
    logic [31:0]   ip;
    logic          zflag;
    bit            miss;
    logic [MA-1:0] miss_at;

    job_t     job_q [$];
    outcome_t result_q [$];
    int       errors = 0;
    int       n_items = 0;
    int       n_out = 0;
    int       cycles = 0;
    bit       offering = 0;

    function automatic logic [7:0] rd1(input logic [31:0] a);
        if (!loaded[a[MA-1:0]] && !miss) begin
            miss = 1;
            miss_at = a[MA-1:0];
        end
        return shadow_mem[a[MA-1:0]];
    endfunction

    function automatic logic [31:0] rd4(input logic [31:0] a);
        return {rd1(a + 3), rd1(a + 2), rd1(a + 1), rd1(a)};
    endfunction

    function automatic void mark(input logic [31:0] a, input logic [7:0] v);
        shadow_mem[a[MA-1:0]] = v;
        if (!loaded[a[MA-1:0]]) loaded_list.push_back(a[MA-1:0]);
        loaded[a[MA-1:0]] = 1;
    endfunction

    function automatic logic [7:0] fetch1();
        logic [7:0] b;
        b = rd1(ip);
        ip = ip + 1;
        return b;
    endfunction

    function automatic logic [31:0] fetch4();
        logic [31:0] v;
        v = rd4(ip);
        ip = ip + 4;
        return v;
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // one operation on the shadow machine; a trial run leaves the state as it was
    function automatic outcome_t execute(input mx86_pkg::op_t op, input logic [31:0] addr,
                                         input logic [63:0] data, input bit trial);
        outcome_t    r;
        logic [63:0] gpr_sv [8];
        logic [31:0] ip_sv;
        logic        zf_sv;
        logic [7:0]  b, m;
        logic [1:0]  md;
        logic [2:0]  rg, rm;
        logic [31:0] ea;
        logic [63:0] v;
        int          n;
        r = '{default: '0};
        gpr_sv = gpr;
        ip_sv = ip;
        zf_sv = zflag;
        miss = 0;
        case (op)
            mx86_pkg::OP_LOAD: if (!trial) mark(addr, data[7:0]);
            mx86_pkg::OP_READ: r.rbyte = rd1(addr);
            mx86_pkg::OP_RESTART: begin
                foreach (gpr[i]) gpr[i] = '0;
                gpr[4] = data;
                ip = addr;
                zflag = 0;
            end
            default: begin
                n = 0;
                b = fetch1();
                while (n < mx86_pkg::MAX_PREFIXES
                       && (b[7:4] == 4'h4 || b == 8'h66 || b == 8'h67)) begin
                    b = fetch1();
                    n++;
                end
                r.opc = b;
                if (b == mx86_pkg::OPC_ADD || b == mx86_pkg::OPC_XOR
                    || b == mx86_pkg::OPC_MOV) begin
                    m = fetch1();
                    md = m[7:6];
                    rg = m[5:3];
                    rm = m[2:0];
                    if (md == 2'd3) begin
                        if (b == mx86_pkg::OPC_ADD) v = gpr[rm] + gpr[rg];
                        else if (b == mx86_pkg::OPC_XOR) v = gpr[rm] ^ gpr[rg];
                        else v = gpr[rg];
                        gpr[rm] = v;
                        r.rwv = 1; r.ridx = rm; r.rval = v;
                    end else begin
                        ea = gpr[rm][31:0];
                        if (md == 2'd1) ea = ea + sx8(fetch1());
                        else if (md == 2'd2) ea = ea + fetch4();
                        if (b == mx86_pkg::OPC_MOV) v = gpr[rg];
                        else if (b == mx86_pkg::OPC_ADD) v = {32'd0, rd4(ea)} + gpr[rg];
                        else v = {32'd0, rd4(ea)} ^ gpr[rg];
                        if (!trial)
                            for (int i = 0; i < 8; i++) mark(ea + i, v[8*i +: 8]);
                        r.mwv = 1; r.maddr = ea; r.mdata = v;
                    end
                end else if (b == mx86_pkg::OPC_MOVA || b == mx86_pkg::OPC_MOVC) begin
                    rm = (b == mx86_pkg::OPC_MOVA) ? 3'd0 : 3'd1;
                    gpr[rm] = {32'd0, fetch4()};
                    r.rwv = 1; r.ridx = rm; r.rval = gpr[rm];
                end else if (b == mx86_pkg::OPC_GRP5) begin
                    m = fetch1();
                    if (m[5:3] == 3'd1) begin
                        gpr[m[2:0]] = gpr[m[2:0]] - 1;
                        r.rwv = 1; r.ridx = m[2:0]; r.rval = gpr[m[2:0]];
                    end
                end else if (b == mx86_pkg::OPC_CMP) begin
                    m = fetch1();
                    if (m[5:3] == 3'd7) begin
                        if (m[7:6] == 2'd3) zflag = (gpr[m[2:0]] == {56'd0, fetch1()});
                        else if (m[7:6] == 2'd0) zflag = (gpr[m[2:0]] == {32'd0, fetch4()});
                    end
                end else if (b == mx86_pkg::OPC_JNE || b == mx86_pkg::OPC_JMP) begin
                    ea = sx8(rd1(ip));
                    if (b == mx86_pkg::OPC_JMP || !zflag) ip = ip + ea;
                    ip = ip + 1;
                end else if (b == mx86_pkg::OPC_HLT) begin
                    ip = '0;
                end
            end
        endcase
        r.next_pc = ip;
        r.zf = zflag;
        if (trial) begin
            gpr = gpr_sv;
            ip = ip_sv;
            zflag = zf_sv;
        end
        return r;
    endfunction

    function automatic void add_job(input mx86_pkg::op_t op, input logic [31:0] a,
                                    input logic [63:0] d, input bit drain = 0);
        job_t j;
        j.op = op; j.addr = a; j.data = d; j.drain = drain;
        j.want = execute(op, a, d, 0);
        job_q.push_back(j);
        n_items++;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // a step never touches a byte the block has not been given: fill gaps first
    function automatic void add_step();
        outcome_t r;
        forever begin
            r = execute(mx86_pkg::OP_STEP, '0, '0, 1);
            if (!miss) break;
            add_job(mx86_pkg::OP_LOAD, {16'($urandom_range(16'hFFFF, 0)), miss_at}, rand64());
        end
        add_job(mx86_pkg::OP_STEP, $urandom, rand64());
    endfunction

    function automatic void put_bytes(input logic [31:0] a, input logic [7:0] bytes [$]);
        foreach (bytes[i])
            add_job(mx86_pkg::OP_LOAD, a + i, {$urandom, 24'd0, bytes[i]});
    endfunction

    function automatic void add_read();
        logic [MA-1:0] k;
        k = loaded_list[$urandom_range(loaded_list.size() - 1, 0)];
        add_job(mx86_pkg::OP_READ, {16'($urandom_range(16'hFFFF, 0)), k}, rand64());
    endfunction

    function automatic void gen_instr(output logic [7:0] q [$]);
        logic [7:0] pick [10] = '{mx86_pkg::OPC_ADD, mx86_pkg::OPC_XOR, mx86_pkg::OPC_MOV,
                                  mx86_pkg::OPC_MOVA, mx86_pkg::OPC_MOVC,
                                  mx86_pkg::OPC_GRP5, mx86_pkg::OPC_CMP, mx86_pkg::OPC_JNE,
                                  mx86_pkg::OPC_JMP, mx86_pkg::OPC_HLT};
        logic [7:0] prefix [4] = '{8'h48, 8'h66, 8'h67, 8'h40};
        logic [7:0] b, m;
        int np;
        q = {};
        np = ($urandom_range(99, 0) < 65) ? 0 : $urandom_range(3, 1);
        if ($urandom_range(99, 0) < 3) np = $urandom_range(16, 13);
        repeat (np) q.push_back(($urandom_range(1, 0)) ? prefix[$urandom_range(3, 0)]
                                                        : {4'h4, 4'($urandom)});
        b = ($urandom_range(9, 0) == 0) ? 8'($urandom) : pick[$urandom_range(9, 0)];
        q.push_back(b);
        m = 8'($urandom);
        if (b == mx86_pkg::OPC_GRP5 && $urandom_range(9, 0) < 7) m[5:3] = 3'd1;
        if (b == mx86_pkg::OPC_CMP && $urandom_range(9, 0) < 7) m[5:3] = 3'd7;
        if ((b == mx86_pkg::OPC_ADD || b == mx86_pkg::OPC_XOR || b == mx86_pkg::OPC_MOV)
            && $urandom_range(1, 0))
            m[7:6] = 2'd3;
        if (b == mx86_pkg::OPC_MOVA || b == mx86_pkg::OPC_MOVC) begin
            if ($urandom_range(1, 0)) q.push_back(8'($urandom_range(255, 0)));
            else q.push_back(8'($urandom));
            repeat (3) q.push_back(($urandom_range(1, 0)) ? 8'($urandom) : 8'd0);
        end else if (b == mx86_pkg::OPC_CMP && m[7:6] == 2'd3 && gpr[m[2:0]] < 256
                     && $urandom_range(1, 0)) begin
            q.push_back(m);
            q.push_back(gpr[m[2:0]][7:0]);
        end else begin
            q.push_back(m);
            repeat (5) q.push_back(8'($urandom));
        end
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_out);
        errors++;
    endtask

    // output side
    always @(posedge aclk) begin
        outcome_t got, w;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                result_q.push_back(job_q[0].want);
                void'(job_q.pop_front());
                offering = 0;
            end
            if (m_tvalid && m_tready) begin
                got.next_pc = m_tdata[31:0];
                got.zf      = m_tdata[32];
                got.opc     = m_tdata[40:33];
                got.rwv     = m_tdata[41];
                got.ridx    = m_tdata[44:42];
                got.rval    = m_tdata[108:45];
                got.mwv     = m_tdata[109];
                got.maddr   = m_tdata[141:110];
                got.mdata   = m_tdata[205:142];
                got.rbyte   = m_tdata[213:206];
                if (result_q.size() == 0) begin
                    report("unexpected transaction", m_tdata[63:0], '0);
                end else begin
                    w = result_q.pop_front();
                    if (got.next_pc !== w.next_pc) report("next_pc", got.next_pc, w.next_pc);
                    if (got.zf !== w.zf) report("zero_flag", got.zf, w.zf);
                    if (got.opc !== w.opc) report("opcode", got.opc, w.opc);
                    if (got.rwv !== w.rwv) report("reg_write_valid", got.rwv, w.rwv);
                    if (got.ridx !== w.ridx) report("reg_index", got.ridx, w.ridx);
                    if (got.rval !== w.rval) report("reg_value", got.rval, w.rval);
                    if (got.mwv !== w.mwv) report("mem_write_valid", got.mwv, w.mwv);
                    if (got.maddr !== w.maddr) report("mem_address", got.maddr, w.maddr);
                    if (got.mdata !== w.mdata) report("mem_data", got.mdata, w.mdata);
                    if (got.rbyte !== w.rbyte) report("read_byte", got.rbyte, w.rbyte);
                end
                n_out++;
            end
        end
    end

    // input side: bursts with gaps
    int burst = 4;
    int gap = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!offering) begin
            if (gap > 0) begin
                gap--;
                s_tvalid <= 1'b0;
            end else if (job_q.size() > 0 && (!job_q[0].drain || result_q.size() == 0)) begin
                s_tvalid <= 1'b1;
                s_tdata <= {6'd0, job_q[0].data, job_q[0].addr, job_q[0].op};
                offering = 1;
                if (--burst <= 0) begin
                    burst = $urandom_range(24, 1);
                    gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, plus one long hold-off
    int hold = 0;
    bit held = 0;
    int rmode = 0;
    always @(negedge aclk) begin
        if (cycles % 80 == 0) rmode = $urandom_range(3, 0);
        if (hold > 0) begin
            hold--;
            m_tready <= 1'b0;
        end else if (!held && n_out >= 300) begin
            held = 1;
            hold = 400;
            m_tready <= 1'b0;
        end else begin
            case (rmode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(1, 0) == 1);
                2: m_tready <= ($urandom_range(3, 0) == 0);
                default: m_tready <= (cycles % 7 != 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [7:0] prog [$];
        logic [31:0] base;
        int k;
        foreach (gpr[i]) gpr[i] = '0;
        ip = '0;
        zflag = 0;

        // directed program touching every opcode form
        prog = '{8'hB8, 8'hFF, 8'hFF, 8'hFF, 8'hFF,  8'hB9, 8'h00, 8'h20, 8'h00, 8'h00,
                 8'h01, 8'hC8,  8'h31, 8'hC8,  8'h48, 8'h66, 8'h67, 8'h89, 8'h01,
                 8'h01, 8'h41, 8'hF8,  8'h31, 8'h81, 8'h10, 8'h00, 8'h00, 8'h00,
                 8'hFF, 8'hC8,  8'hFF, 8'hC0,  8'hB8, 8'h05, 8'h00, 8'h00, 8'h00,
                 8'h83, 8'hF8, 8'h05,  8'h75, 8'h02,  8'h83, 8'h39, 8'h00, 8'h20, 8'h00,
                 8'h00,  8'h83, 8'h79,  8'h83, 8'hC1,  8'h83, 8'hF8, 8'h07,  8'h75, 8'h02,
                 8'h90, 8'h90,  8'hEB, 8'h00,  8'h89, 8'hC1};
        repeat (15) prog.push_back(8'h40);
        prog.push_back(mx86_pkg::OPC_HLT);
        put_bytes(32'h0000_0100, prog);
        add_job(mx86_pkg::OP_RESTART, 32'h0000_0100, 64'hFFFF_FFFF_FFFF_FFFF);
        add_read();
        repeat (22) add_step();
        // pointer wrap and backward jump
        put_bytes(32'hFFFF_FFFE, '{8'h90, 8'hEB});
        add_job(mx86_pkg::OP_LOAD, 32'h0000_0000, 64'hFE, 1);
        add_job(mx86_pkg::OP_RESTART, 32'hFFFF_FFFE, 64'h0);
        repeat (3) add_step();

        while (n_items < N_ITEMS) begin
            k = $urandom_range(99, 0);
            if (k < 75) begin
                if ($urandom_range(4, 0) == 0) begin
                    base = $urandom;
                    add_job(mx86_pkg::OP_RESTART, base, rand64(), $urandom_range(30, 0) == 0);
                end
                base = ip;
                k = $urandom_range(6, 1);
                repeat (k) begin
                    gen_instr(prog);
                    put_bytes(base, prog);
                    base = base + prog.size();
                end
                repeat (k) add_step();
            end else if (k < 85) begin
                add_read();
            end else if (k < 95) begin
                add_job(mx86_pkg::OP_LOAD, $urandom, rand64());
            end else begin
                add_step();
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (job_q.size() > 0 || offering || result_q.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
